FILE: rtl/core/iact_pkg.sv
// Shared types, codes and helpers for the address hit-count table.
package iact_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SET    = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Request held for the whole pass; key already normalised per family
    typedef struct packed {
        logic [1:0]  mode;
        logic        is_v6;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] new_count;
    } req_t;

    // Token handed from cell to cell along the row
    typedef struct packed {
        logic        active;
        logic        found;
        logic        claimed;
        logic [31:0] count;
    } token_t;

    // End-of-pass broadcast to all cells
    typedef struct packed {
        logic done;
        logic commit;
    } ctl_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] value);
        logic [31:0] res;
        res = (value == COUNT_MAX) ? value : value + 32'd1;
        return res;
    endfunction

endpackage

FILE: rtl/core/iact_cell.sv
// One table entry: compares the passing key, updates itself and forwards the token.
module iact_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  iact_pkg::req_t   req,
    input  iact_pkg::ctl_t   ctl,
    input  iact_pkg::token_t tok_in,
    output iact_pkg::token_t tok_out
);
    import iact_pkg::*;

    logic        valid_reg;
    logic        pending_reg;
    logic        is_v6_reg;
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [31:0] count_reg;
    token_t      tok_reg;
    token_t      tok_next;

    logic        hit;
    logic        claim;
    logic [31:0] count_inc;

    assign hit = tok_in.active && valid_reg && (is_v6_reg == req.is_v6) &&
                 (key_high_reg == req.key_high) && (key_low_reg == req.key_low);
    // lowest free entry, taken only while no match has been seen yet
    assign claim = tok_in.active && (req.mode == MODE_INSERT) && !valid_reg &&
                   !tok_in.claimed && !tok_in.found;
    assign count_inc = sat_inc(count_reg);

    always_comb begin
        tok_next = tok_in;
        if (hit) begin
            tok_next.found = 1'b1;
            tok_next.count = (req.mode == MODE_INSERT) ? count_inc : count_reg;
        end else if (claim) begin
            tok_next.claimed = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg.found   <= tok_next.found;
        tok_reg.claimed <= tok_next.claimed;
        tok_reg.count   <= tok_next.count;
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
            valid_reg      <= 1'b0;
            pending_reg    <= 1'b0;
        end else begin
            tok_reg.active <= tok_next.active;
            if (hit && req.mode == MODE_REMOVE) begin
                valid_reg <= 1'b0;
            end else if (ctl.done && ctl.commit && pending_reg) begin
                valid_reg <= 1'b1;
            end
            if (ctl.done) begin
                pending_reg <= 1'b0;
            end else if (claim) begin
                pending_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (claim) begin
            // entry stays invalid until the end-of-pass commit
            is_v6_reg    <= req.is_v6;
            key_high_reg <= req.key_high;
            key_low_reg  <= req.key_low;
            count_reg    <= 32'd1;
        end else if (hit && req.mode == MODE_INSERT) begin
            count_reg <= count_inc;
        end else if (hit && req.mode == MODE_SET) begin
            count_reg <= req.new_count;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/core/ip_address_count_table.sv
// Top level of the IPv4/IPv6 address hit-count table.
//
// Requests arrive on the s_ stream: tuser carries the opcode and the address
// family, tdata the address halves and the count for a set. Each request
// gives exactly one result beat on the m_ stream: tuser the status, tdata
// the count. Keys of the two families never match each other.
//
// The table is a row of TABLE_ENTRIES cells. A request token walks the row,
// one cell per cycle; the matching cell updates itself on the spot and the
// lowest free cell reserves itself for a new key, which is committed once the
// token leaves the row without a match. One request is in the row at a time:
// the token passes the input register and every cell, the end-of-row register
// holds the outcome until the output register is free, and the next request
// is accepted in the cycle after the previous one has left for the output
// register.
//
// Reset clears every valid mark and any token in flight; the table is usable
// as soon as reset is released. A stalled m_tready holds the result; no
// further request is accepted until that result moves to the output register.
module ip_address_count_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // address_high, address_low, new_count
    input  logic [2:0]   s_tuser,  // mode, is_ipv6
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // count
    output logic [1:0]   m_tuser   // status
);
    import iact_pkg::*;

    req_t        req_reg;
    token_t      inj_reg;
    token_t      fin_reg;
    logic        fin_valid_reg;
    logic        busy_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    token_t      tok [0:TABLE_ENTRIES];
    ctl_t        ctl;
    logic        s_beat;
    logic        fin_move;
    logic [1:0]  res_status;
    logic [31:0] res_count;

    assign s_tready = aresetn && !busy_reg;
    assign s_beat   = s_tvalid && s_tready;
    assign fin_move = fin_valid_reg && (!m_tvalid_reg || m_tready);

    assign ctl.done   = fin_move;
    assign ctl.commit = (req_reg.mode == MODE_INSERT) && !fin_reg.found && fin_reg.claimed;

    assign tok[0] = inj_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            iact_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .req     (req_reg),
                .ctl     (ctl),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    always_comb begin
        res_status = ST_ABSENT;
        res_count  = 32'd0;
        case (req_reg.mode)
            MODE_INSERT: begin
                if (fin_reg.found) begin
                    res_status = ST_OK;
                    res_count  = fin_reg.count;
                end else if (fin_reg.claimed) begin
                    res_status = ST_OK;
                    res_count  = 32'd1;
                end else begin
                    res_status = ST_FULL;
                end
            end
            MODE_REMOVE, MODE_SET: begin
                if (fin_reg.found) begin
                    res_status = ST_OK;
                    res_count  = fin_reg.count;
                end
            end
            default: begin
                res_status = ST_ABSENT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            inj_reg       <= '0;
            fin_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // only the active flag moves; the other token fields stay clear
            inj_reg.active <= s_beat;
            if (s_beat) begin
                busy_reg <= 1'b1;
            end else if (fin_move) begin
                busy_reg <= 1'b0;
            end
            if (tok[TABLE_ENTRIES].active) begin
                fin_valid_reg <= 1'b1;
            end else if (fin_move) begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            // normalise the key: IPv4 keeps only the low 32 address bits
            req_reg.mode      <= s_tuser[1:0];
            req_reg.is_v6     <= s_tuser[2];
            req_reg.key_high  <= s_tuser[2] ? s_tdata[63:0] : 64'd0;
            req_reg.key_low   <= s_tuser[2] ? s_tdata[127:64] : {32'd0, s_tdata[95:64]};
            req_reg.new_count <= s_tdata[159:128];
        end
        if (tok[TABLE_ENTRIES].active) begin
            fin_reg <= tok[TABLE_ENTRIES];
        end
        if (fin_move) begin
            m_tdata_reg <= res_count;
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the IPv4/IPv6 address hit-count table.
`timescale 1ns / 100ps

module tb_top;
    import iact_pkg::*;

    localparam int          TABLE_ENTRIES = 256;
    localparam int          KEY_POOL      = 300;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    // Idle limit long enough for one request through the row plus the long hold-off
    localparam int          IDLE_LIMIT    = 20000;
    localparam int          DRAIN_CYCLES  = 2 * (TABLE_ENTRIES + 3);

    typedef struct {
        logic [1:0]  status;
        logic [31:0] count;
    } reply_t;

    // Associative table mirror plus the queue of replies it predicts
    class hit_table_scoreboard;
        bit          used [TABLE_ENTRIES];
        bit          fam_v6 [TABLE_ENTRIES];
        logic [63:0] key_high [TABLE_ENTRIES];
        logic [63:0] key_low [TABLE_ENTRIES];
        logic [31:0] hits [TABLE_ENTRIES];
        reply_t      awaiting [$];
        int          errors;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                used[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function void note_request(input logic [1:0] mode, input logic v6,
                                   input logic [63:0] hi, input logic [63:0] lo,
                                   input logic [31:0] new_count);
            logic [63:0] kh;
            logic [63:0] kl;
            int          slot;
            int          spare;
            reply_t      r;
            // IPv4 keys use only the low 32 address bits
            kh = v6 ? hi : 64'd0;
            kl = v6 ? lo : {32'd0, lo[31:0]};
            slot = -1;
            spare = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (used[i] && fam_v6[i] == v6 && key_high[i] == kh && key_low[i] == kl
                    && slot < 0)
                    slot = i;
                if (!used[i] && spare < 0)
                    spare = i;
            end
            r.status = ST_ABSENT;
            r.count = 32'd0;
            case (mode)
                MODE_INSERT: begin
                    if (slot >= 0) begin
                        if (hits[slot] != COUNT_MAX)
                            hits[slot] = hits[slot] + 32'd1;
                        r.status = ST_OK;
                        r.count = hits[slot];
                    end else if (spare >= 0) begin
                        used[spare] = 1'b1;
                        fam_v6[spare] = v6;
                        key_high[spare] = kh;
                        key_low[spare] = kl;
                        hits[spare] = 32'd1;
                        r.status = ST_OK;
                        r.count = 32'd1;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                MODE_REMOVE: begin
                    if (slot >= 0) begin
                        r.status = ST_OK;
                        r.count = hits[slot];
                        used[slot] = 1'b0;
                    end
                end
                MODE_SET: begin
                    if (slot >= 0) begin
                        r.status = ST_OK;
                        r.count = hits[slot];
                        hits[slot] = new_count;
                    end
                end
                default: begin
                end
            endcase
            awaiting.push_back(r);
        endfunction

        function void check_result(input logic [1:0] status, input logic [31:0] count);
            reply_t r;
            if (awaiting.size() == 0) begin
                $display("%0t: unexpected result status=%0d count=%h", $time, status, count);
                errors++;
                return;
            end
            r = awaiting.pop_front();
            if (status !== r.status) begin
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, r.status, status);
                errors++;
            end
            if (count !== r.count) begin
                $display("%0t: count mismatch expected=%h actual=%h", $time, r.count, count);
                errors++;
            end
        endfunction

        function int pending();
            return awaiting.size();
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;   // address_high, address_low, new_count
    logic [2:0]   s_tuser;   // mode, is_ipv6
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;   // count
    logic [1:0]   m_tuser;   // status

    hit_table_scoreboard sb;
    int          replies_seen = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          pool_v6 [KEY_POOL];
    logic [63:0] pool_high [KEY_POOL];
    logic [63:0] pool_low [KEY_POOL];

    ip_address_count_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Note accepted requests and check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser[1:0], s_tuser[2], s_tdata[63:0], s_tdata[127:64],
                                s_tdata[159:128]);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tuser, m_tdata);
                replies_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result side: changing stall styles, plus one long hold-off to back up the input
    initial begin
        int stall_left;
        int style;
        int style_left;
        bit held;
        stall_left = 0;
        style = 0;
        style_left = 0;
        held = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && replies_seen >= 150) begin
                held = 1'b1;
                stall_left = 2000;
            end
            if (style_left == 0) begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(50, 600);
            end else begin
                style_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if ($urandom_range(0, 31) == 0)
                            stall_left = $urandom_range(20, 300);
                        m_tready <= 1'b1;
                    end
                endcase
            end
        end
    end

    // Offer one request, opening a new burst after a random gap when the last one ran out
    task automatic send_request(input logic [1:0] mode, input logic v6, input logic [63:0] hi,
                                input logic [63:0] lo, input logic [31:0] new_count);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(0, 2);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {new_count, lo, hi};
        s_tuser <= {v6, mode};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return $urandom_range(0, 3);
        if (r < 5)
            return COUNT_MAX - $urandom_range(0, 2);
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_mode(input int ins, input int rem, input int set);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins)
            return MODE_INSERT;
        if (r < ins + rem)
            return MODE_REMOVE;
        if (r < ins + rem + set)
            return MODE_SET;
        return MODE_UNUSED;
    endfunction

    // Send a pool key; IPv4 keys get fresh junk in the ignored address bits
    task automatic send_pool_key(input logic [1:0] mode, input int idx);
        logic [63:0] hi;
        logic [63:0] lo;
        if (pool_v6[idx]) begin
            hi = pool_high[idx];
            lo = pool_low[idx];
        end else begin
            hi = {$urandom, $urandom};
            lo = {$urandom, pool_low[idx][31:0]};
        end
        send_request(mode, pool_v6[idx], hi, lo, pick_count());
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;

        for (int i = 0; i < KEY_POOL; i++) begin
            pool_v6[i] = i[0];
            pool_high[i] = ($urandom_range(0, 7) == 0) ? 64'd0 : {$urandom, $urandom};
            pool_low[i] = {$urandom, $urandom};
            // IPv6 twin of the previous IPv4 key: same low bits, other family
            if (i % 8 == 1) begin
                pool_high[i] = 64'd0;
                pool_low[i] = {32'd0, pool_low[i - 1][31:0]};
            end
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: family separation, ignored bits, extremes, saturation, misses
        send_request(MODE_INSERT, 1'b0, 64'hDEAD_BEEF_0123_4567,
                     64'h89AB_CDEF_0A00_0001, 32'd0);
        send_request(MODE_INSERT, 1'b1, 64'd0, 64'h0000_0000_0A00_0001, 32'd0);
        send_request(MODE_INSERT, 1'b0, 64'h0, 64'hFFFF_FFFF_0A00_0001, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 1'b1, '1, '1, '1);
        send_request(MODE_INSERT, 1'b0, '1, 64'h0000_0000_FFFF_FFFF, 32'd0);
        send_request(MODE_INSERT, 1'b0, 64'd0, 64'd0, 32'd0);
        send_request(MODE_INSERT, 1'b1, 64'd0, 64'd0, 32'd0);
        send_request(MODE_SET, 1'b0, 64'd5, 64'h0000_0001_0A00_0001, COUNT_MAX - 32'd1);
        send_request(MODE_INSERT, 1'b0, 64'd0, 64'h0000_0000_0A00_0001, 32'd0);
        send_request(MODE_INSERT, 1'b0, 64'd0, 64'h0000_0000_0A00_0001, 32'd0);
        send_request(MODE_SET, 1'b1, '1, '1, 32'd0);
        send_request(MODE_INSERT, 1'b1, '1, '1, 32'd0);
        send_request(MODE_SET, 1'b1, '1, '1, 32'd0);
        send_request(MODE_REMOVE, 1'b1, '1, '1, 32'd0);
        send_request(MODE_REMOVE, 1'b1, '1, '1, 32'd0);
        send_request(MODE_SET, 1'b1, 64'h1234, 64'h5678, 32'd77);
        send_request(MODE_UNUSED, 1'b0, 64'd0, 64'h0000_0000_0A00_0001, 32'd9);
        send_request(MODE_INSERT, 1'b0, 64'd0, 64'h0000_0000_0A00_0001, 32'd0);
        send_request(MODE_REMOVE, 1'b0, 64'd0, 64'h0000_0000_0A00_0001, 32'd0);
        send_request(MODE_REMOVE, 1'b0, '1, 64'hFFFF_FFFF_0000_0000, 32'd0);
        send_request(MODE_REMOVE, 1'b1, 64'd0, 64'd0, 32'd0);

        // Fill: walk the pool with inserts past capacity, with some other traffic mixed in
        for (int i = 0; i < 290; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_pool_key(pick_mode(30, 25, 35), $urandom_range(0, KEY_POOL - 1));
            send_pool_key(MODE_INSERT, i);
        end

        // Churn near capacity
        for (int i = 0; i < 500; i++)
            send_pool_key(pick_mode(45, 20, 28), $urandom_range(0, KEY_POOL - 1));

        // Drain
        for (int i = 0; i < 230; i++)
            send_pool_key(pick_mode(20, 60, 15), $urandom_range(0, KEY_POOL - 1));

        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
